// ===== hw/rtl/cbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_pkg: shared types and constants of the coefficient bit packer
// Register indexes, width codes, the per-item result run and width helpers.
// ----------------------------------------------------------------------------
package cbp_pkg;

   localparam int CoeffsPerPoly = 256;
   localparam int CntW          = $clog2(CoeffsPerPoly);
   localparam int MaxRun        = 3;
   localparam int RunCntW       = 2;
   localparam int CsrIdxW       = 2;
   localparam int CsrDataW      = 2;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_DIRECTION    = 2'd0,
      CSR_WIDTH_SELECT = 2'd1
   } csr_index_type;

   typedef enum logic {
      DIR_PACK   = 1'b0,
      DIR_UNPACK = 1'b1
   } dir_type;

   typedef enum logic [1:0] {
      WS_3BIT = 2'd0,
      WS_5BIT = 2'd1,
      WS_6BIT = 2'd2,
      WS_8BIT = 2'd3
   } width_sel_type;

   // results caused by one item, first result in vals[0]
   typedef struct packed {
      logic [MaxRun-1:0][7:0] vals;
      logic [RunCntW-1:0]     count;
      logic                   poly_end;
   } run_type;

   function automatic logic [3:0] width_of(width_sel_type ws);
      logic [3:0] w;
      unique case (ws)
         WS_3BIT: w = 4'd3;
         WS_5BIT: w = 4'd5;
         WS_6BIT: w = 4'd6;
         WS_8BIT: w = 4'd8;
         default: w = 4'd8;
      endcase
      return w;
   endfunction

   function automatic logic [7:0] mask_of(width_sel_type ws);
      logic [7:0] m;
      unique case (ws)
         WS_3BIT: m = 8'h07;
         WS_5BIT: m = 8'h1f;
         WS_6BIT: m = 8'h3f;
         WS_8BIT: m = 8'hff;
         default: m = 8'hff;
      endcase
      return m;
   endfunction

   // how many whole coefficients fit in t bits, at most three
   function automatic logic [RunCntW-1:0] fit_count(logic [4:0] t, logic [3:0] w);
      logic [RunCntW-1:0] n;
      if (t >= 5'(3 * w)) begin
         n = 2'd3;
      end else if (t >= 5'(2 * w)) begin
         n = 2'd2;
      end else if (t >= 5'(w)) begin
         n = 2'd1;
      end else begin
         n = 2'd0;
      end
      return n;
   endfunction

endpackage

// ===== hw/rtl/coeff_bit_pack_unpack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coeff_bit_pack_unpack: streaming coefficient bit packer and unpacker
// Packs 3/5/6/8-bit coefficients into bytes, or unpacks bytes into them.
// ----------------------------------------------------------------------------
// Usage:
//  req_ channel takes one coefficient (pack) or one byte (unpack) per beat.
//  rsp_ channel gives each result beat; rsp_run_end marks the last beat an
//  item caused, rsp_poly_end the last beat of the polynomial.
//  An item's results are built in the cycle it is taken and held in a
//  three-entry result register; the first beat shows in the cycle after.
//  Throughput: one item per cycle while each makes at most one beat and rsp_
//  is unstalled; an item making more beats holds the next off until its last
//  beat goes, the register draining one beat a cycle when unstalled. Items
//  making no beat (pack, byte not full) are taken each cycle unless req_stall.
//  A stall on rsp_ holds the current beat; req_stall rises once the
//  result register cannot take another run.
//  csr_ writes clear the bit buffer and coefficient counter; write only
//  while no beat is outstanding.
//  Reset: pack, five-bit, empty buffer, no beat pending.
// ----------------------------------------------------------------------------
module coeff_bit_pack_unpack (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [cbp_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [cbp_pkg::CsrDataW-1:0] csr_wdata,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_in_value,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [7:0]                   rsp_out_value,
   output logic                         rsp_run_end,
   output logic                         rsp_poly_end
);
   import cbp_pkg::*;

   run_type run;
   logic    can_load;
   logic    take;
   logic    load;

   assign req_stall = !can_load;
   assign take      = req_valid && can_load;
   assign load      = take && run.count != '0;

   cbp_engine u_engine (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .take         (take),
      .item         (req_in_value),
      .run          (run)
   );

   cbp_run_buf u_run_buf (
      .clock         (clock),
      .reset         (reset),
      .load          (load),
      .run           (run),
      .can_load      (can_load),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_value (rsp_out_value),
      .rsp_run_end   (rsp_run_end),
      .rsp_poly_end  (rsp_poly_end)
   );

`ifndef SYNTHESIS
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result beat right after reset");

   a_poly_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_poly_end |-> rsp_run_end)
      else $error("polynomial end not on last beat of a run");

   a_stall_when_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && !rsp_run_end |-> req_stall)
      else $error("input taken while a run is still pending");

   a_load_has_beats: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid)
      else $error("loaded run produced no beat");
`endif

endmodule

// ===== hw/rtl/cbp_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_engine: bit buffer, coefficient counter and config registers
// Builds the whole run of results for one item combinationally and updates
// the stream state when the item is taken.
// ----------------------------------------------------------------------------
module cbp_engine (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_write_en,
   input  logic [cbp_pkg::CsrIdxW-1:0]  csr_index,
   input  logic [cbp_pkg::CsrDataW-1:0] csr_wdata,
   input  logic                         take,
   input  logic [7:0]                   item,
   output cbp_pkg::run_type             run
);
   import cbp_pkg::*;

   localparam int CW2 = CntW + 2;

   dir_type       dir_ff, dir_in;
   width_sel_type ws_ff, ws_in;
   logic [15:0]   buf_ff, buf_in;
   logic [3:0]    cnt_ff, cnt_in;
   logic [CntW-1:0] coeff_ff, coeff_in;

   logic [3:0]  w;
   logic [7:0]  wmask;
   logic [7:0]  v;
   logic [15:0] sum;
   logic [15:0] rest;
   logic [4:0]  t;
   logic [4:0]  used;
   logic [RunCntW-1:0] n;
   logic [RunCntW-1:0] fit;
   logic        last;
   logic        found;
   logic        clear;
   logic [CntW-1:0] coeff_next;

   assign w     = width_of(ws_ff);
   assign wmask = mask_of(ws_ff);
   assign v     = item & wmask;
   assign last  = coeff_ff == CntW'(CoeffsPerPoly - 1);

   always_comb begin
      run        = '0;
      n          = '0;
      fit        = '0;
      found      = 1'b0;
      clear      = 1'b0;
      used       = '0;
      sum        = '0;
      rest       = '0;
      t          = '0;
      coeff_next = coeff_ff;
      if (dir_ff == DIR_PACK) begin
         t = 5'(cnt_ff) + 5'(w);
         if (ws_ff == WS_3BIT) begin
            sum = (buf_ff << w) | 16'(v);
            if (t >= 5'd8) begin
               run.vals[0] = 8'(sum >> (t - 5'd8));
               n = 2'd1;
               t = t - 5'd8;
            end
         end else begin
            sum = buf_ff | (16'(v) << cnt_ff);
            if (t >= 5'd8) begin
               run.vals[0] = sum[7:0];
               n = 2'd1;
               sum = sum >> 8;
               t = t - 5'd8;
            end
         end
         rest = sum & ((16'd1 << t) - 16'd1);
         if (last) begin
            clear = 1'b1;
            if (t != 5'd0) begin
               // partial byte, padded with zeros
               run.vals[n] = (ws_ff == WS_3BIT) ? 8'(rest << (5'd8 - t)) : rest[7:0];
               n = n + 2'd1;
            end
            run.poly_end = 1'b1;
         end else begin
            coeff_next = coeff_ff + CntW'(1);
         end
      end else begin
         t = 5'(cnt_ff) + 5'd8;
         if (ws_ff == WS_3BIT) begin
            sum = (buf_ff << 8) | 16'(item);
         end else begin
            sum = buf_ff | (16'(item) << cnt_ff);
         end
         fit = fit_count(t, w);
         n   = fit;
         for (int k = 0; k < MaxRun; k++) begin
            if (ws_ff == WS_3BIT) begin
               run.vals[k] = 8'(sum >> 5'(t - 5'(3 * (k + 1)))) & wmask;
            end else begin
               run.vals[k] = 8'(sum >> 5'(k * w)) & wmask;
            end
            if (!found && RunCntW'(k) < fit &&
                ({2'b00, coeff_ff} + CW2'(k)) == CW2'(CoeffsPerPoly - 1)) begin
               found = 1'b1;
               n = RunCntW'(k + 1);
            end
         end
         unique case (n)
            2'd0:    used = 5'd0;
            2'd1:    used = 5'(w);
            2'd2:    used = 5'(2 * w);
            2'd3:    used = 5'(3 * w);
            default: used = 5'd0;
         endcase
         t = t - used;
         if (ws_ff == WS_3BIT) begin
            rest = sum & ((16'd1 << t) - 16'd1);
         end else begin
            rest = (sum >> used) & ((16'd1 << t) - 16'd1);
         end
         if (found) begin
            clear = 1'b1;
            run.poly_end = 1'b1;
         end else begin
            coeff_next = coeff_ff + CntW'(n);
         end
      end
      run.count = n;
   end

   always_comb begin
      dir_in   = dir_ff;
      ws_in    = ws_ff;
      buf_in   = buf_ff;
      cnt_in   = cnt_ff;
      coeff_in = coeff_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_DIRECTION: begin
               dir_in   = dir_type'(csr_wdata[0]);
               buf_in   = '0;
               cnt_in   = '0;
               coeff_in = '0;
            end
            CSR_WIDTH_SELECT: begin
               ws_in    = width_sel_type'(csr_wdata[1:0]);
               buf_in   = '0;
               cnt_in   = '0;
               coeff_in = '0;
            end
            default: begin
            end
         endcase
      end else if (take) begin
         if (clear) begin
            buf_in   = '0;
            cnt_in   = '0;
            coeff_in = '0;
         end else begin
            buf_in   = rest;
            cnt_in   = t[3:0];
            coeff_in = coeff_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= DIR_PACK;
         ws_ff    <= WS_5BIT;
         buf_ff   <= '0;
         cnt_ff   <= '0;
         coeff_ff <= '0;
      end else begin
         dir_ff   <= dir_in;
         ws_ff    <= ws_in;
         buf_ff   <= buf_in;
         cnt_ff   <= cnt_in;
         coeff_ff <= coeff_in;
      end
   end

endmodule

// ===== hw/rtl/cbp_run_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cbp_run_buf: result register that drains one run
// Holds up to three results of one item and hands them out one beat at a time.
// ----------------------------------------------------------------------------
module cbp_run_buf (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  cbp_pkg::run_type run,
   output logic             can_load,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_out_value,
   output logic             rsp_run_end,
   output logic             rsp_poly_end
);
   import cbp_pkg::*;

   logic [MaxRun-1:0][7:0] val_ff, val_in;
   logic [RunCntW-1:0]     cnt_ff, cnt_in;
   logic                   poly_ff, poly_in;
   logic                   pop;

   assign rsp_valid     = cnt_ff != '0;
   assign pop           = rsp_valid && !rsp_stall;
   assign can_load      = (cnt_ff == '0) || (cnt_ff == 2'd1 && pop);
   assign rsp_out_value = val_ff[0];
   assign rsp_run_end   = cnt_ff == 2'd1;
   assign rsp_poly_end  = poly_ff && cnt_ff == 2'd1;

   always_comb begin
      val_in  = val_ff;
      cnt_in  = cnt_ff;
      poly_in = poly_ff;
      if (load) begin
         val_in  = run.vals;
         cnt_in  = run.count;
         poly_in = run.poly_end;
      end else if (pop) begin
         val_in  = {8'h00, val_ff[MaxRun-1:1]};
         cnt_in  = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         poly_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         poly_ff <= poly_in;
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule
